// ===== rtl/plbt_pkg.sv =====
package plbt_pkg;

  // Default number of price levels kept on each side
  localparam int unsigned LevelsPerSideDefault = 64;

  // Payload widths
  localparam int unsigned PriceW  = 32;
  localparam int unsigned VolumeW = 32;
  localparam int unsigned WordW   = PriceW + VolumeW;

  // Operation codes
  typedef enum logic [1:0] {
    OpAdd    = 2'd0,
    OpChange = 2'd1,
    OpDelete = 2'd2,
    OpFind   = 2'd3
  } plbt_op_e;

  // Result status codes
  typedef enum logic [1:0] {
    StatOk   = 2'd0,
    StatMiss = 2'd1,
    StatFull = 2'd2
  } plbt_status_e;

  // Side codes
  localparam logic SidePurchase = 1'b0;
  localparam logic SideSale     = 1'b1;

endpackage

// ===== rtl/plbt_if.sv =====
// Request channel: one book operation per transfer
interface plbt_req_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic                 side;
  logic [31:0]          price;
  logic                 new_side;
  logic [31:0]          new_price;
  logic signed [31:0]   volume;

  modport source (output valid, operation, side, price, new_side, new_price, volume,
                  input ready);
  modport sink   (input valid, operation, side, price, new_side, new_price, volume,
                  output ready);
endinterface

// Response channel: one result per operation
interface plbt_rsp_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic                 found;
  logic signed [31:0]   found_volume;

  modport source (output valid, status, found, found_volume, input ready);
  modport sink   (input valid, status, found, found_volume, output ready);
endinterface

// ===== rtl/plbt_ram.sv =====
module plbt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/price_level_book_table_unit.sv =====
// Channel | Dir | Payload                                          | Transfer
// req_i   | in  | operation, side, price, new_side, new_price, vol | valid && ready
// rsp_o   | out | status, found, found_volume                      | valid && ready
//
// Each operation scans one side of the level memory, one entry per cycle, through
// a single key comparator. A change that moves side or price scans twice.
// A scan stops early at the first matching level. Reset clears the valid bits at once.
// req_i is ready only while the sequencer is idle; a finished result waits in the output
// register while the next request is taken.
module price_level_book_table_unit #(
  parameter int unsigned LEVELS_PER_SIDE = plbt_pkg::LevelsPerSideDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  plbt_req_if.sink   req_i,
  plbt_rsp_if.source rsp_o
);
  import plbt_pkg::*;

  localparam int unsigned IdxW  = $clog2(LEVELS_PER_SIDE);
  localparam int unsigned Depth = 2 * (2 ** IdxW);
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = IdxW + 1;

  typedef enum logic [1:0] {
    SIdle,
    SScan,
    SApply,
    SFinish
  } state_e;

  state_e                 state_q;
  plbt_op_e               op_q;
  logic                   side_q;
  logic [PriceW-1:0]      price_q;
  logic                   nside_q;
  logic [PriceW-1:0]      nprice_q;
  logic [VolumeW-1:0]     vol_q;
  logic                   phase_q;

  logic [CntW-1:0]        cnt_q;
  logic                   pend_q;
  logic [IdxW-1:0]        pidx_q;
  logic                   pvalid_q;
  logic                   hit_q;
  logic [IdxW-1:0]        hidx_q;
  logic [VolumeW-1:0]     hvol_q;
  logic                   free_q;
  logic [IdxW-1:0]        fidx_q;

  logic [Depth-1:0]       valid_q;

  plbt_status_e           res_status_q;
  logic                   res_found_q;
  logic [VolumeW-1:0]     res_fvol_q;
  logic                   out_valid_q;
  plbt_status_e           out_status_q;
  logic                   out_found_q;
  logic [VolumeW-1:0]     out_fvol_q;

  logic                   scan_side;
  logic [PriceW-1:0]      scan_key;
  logic                   move;
  logic                   add_like;
  logic                   issue;
  logic                   hit_now;
  logic [AddrW-1:0]       raddr;
  logic [WordW-1:0]       rdata;

  logic                   we;
  logic [AddrW-1:0]       waddr;
  logic [WordW-1:0]       wdata;
  logic                   set_v;
  logic                   clr_v;
  logic                   restart;
  plbt_status_e           ap_status;
  logic                   ap_found;
  logic [VolumeW-1:0]     ap_fvol;

  // Select the side and key of the current scan
  assign scan_side = phase_q ? nside_q : side_q;
  assign scan_key  = phase_q ? nprice_q : price_q;
  assign move      = (side_q != nside_q) || (price_q != nprice_q);
  assign add_like  = (op_q == OpAdd) || ((op_q == OpChange) && move && phase_q);

  // Issue one read per cycle, compare the word read in the cycle before
  assign issue   = (state_q == SScan) && (cnt_q < CntW'(LEVELS_PER_SIDE));
  assign raddr   = {scan_side, cnt_q[IdxW-1:0]};
  assign hit_now = pend_q && pvalid_q && (rdata[WordW-1:VolumeW] == scan_key);

  plbt_ram #(
    .Width (WordW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Decode the table update and result of a finished scan
  always_comb begin
    we        = 1'b0;
    waddr     = {scan_side, fidx_q};
    wdata     = {scan_key, vol_q};
    set_v     = 1'b0;
    clr_v     = 1'b0;
    restart   = 1'b0;
    ap_status = StatOk;
    ap_found  = 1'b0;
    ap_fvol   = '0;
    if (state_q == SApply) begin
      if (add_like) begin
        if (hit_q) begin
          ap_status = StatMiss;
        end else if (free_q) begin
          we    = 1'b1;
          set_v = 1'b1;
        end else begin
          ap_status = StatFull;
        end
        // A moving change reports ok whatever the add met
        if (op_q == OpChange) begin
          ap_status = StatOk;
        end
      end else begin
        unique case (op_q)
          OpChange: begin
            if (move) begin
              clr_v   = hit_q;
              restart = 1'b1;
            end else if (hit_q) begin
              we    = 1'b1;
              waddr = {scan_side, hidx_q};
            end else begin
              ap_status = StatMiss;
            end
          end
          OpDelete: begin
            if (hit_q) begin
              clr_v = 1'b1;
            end else begin
              ap_status = StatMiss;
            end
          end
          OpFind: begin
            if (hit_q) begin
              ap_found = 1'b1;
              ap_fvol  = hvol_q;
            end else begin
              ap_status = StatMiss;
            end
          end
          default: begin
            ap_status = StatOk;
          end
        endcase
      end
    end
  end

  // Sequencer: state, scan registers, valid bits and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      phase_q     <= 1'b0;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      // Raise valid when a result moves in, drop it after the transfer
      if ((state_q == SFinish) && (!out_valid_q || rsp_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (req_i.valid) begin
            op_q     <= plbt_op_e'(req_i.operation);
            side_q   <= req_i.side;
            price_q  <= req_i.price;
            nside_q  <= req_i.new_side;
            nprice_q <= req_i.new_price;
            vol_q    <= req_i.volume;
            phase_q  <= 1'b0;
            cnt_q    <= '0;
            pend_q   <= 1'b0;
            hit_q    <= 1'b0;
            free_q   <= 1'b0;
            state_q  <= SScan;
          end
        end
        SScan: begin
          pend_q <= issue && !hit_now;
          if (issue) begin
            cnt_q    <= cnt_q + CntW'(1);
            pidx_q   <= cnt_q[IdxW-1:0];
            pvalid_q <= valid_q[raddr];
          end
          if (hit_now) begin
            hit_q   <= 1'b1;
            hidx_q  <= pidx_q;
            hvol_q  <= rdata[VolumeW-1:0];
            state_q <= SApply;
          end else begin
            // Remember the lowest free slot
            if (pend_q && !pvalid_q && !free_q) begin
              free_q <= 1'b1;
              fidx_q <= pidx_q;
            end
            if (!issue) begin
              state_q <= SApply;
            end
          end
        end
        SApply: begin
          if (set_v) begin
            valid_q[waddr] <= 1'b1;
          end
          if (clr_v) begin
            valid_q[{scan_side, hidx_q}] <= 1'b0;
          end
          if (restart) begin
            phase_q <= 1'b1;
            cnt_q   <= '0;
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
            state_q <= SScan;
          end else begin
            res_status_q <= ap_status;
            res_found_q  <= ap_found;
            res_fvol_q   <= ap_fvol;
            state_q      <= SFinish;
          end
        end
        SFinish: begin
          // Hold the result until the output register is free
          if (!out_valid_q || rsp_o.ready) begin
            out_status_q <= res_status_q;
            out_found_q  <= res_found_q;
            out_fvol_q   <= res_fvol_q;
            state_q      <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign req_i.ready        = (state_q == SIdle);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.found        = out_found_q;
  assign rsp_o.found_volume = out_fvol_q;

endmodule
